FILE: hdl/stag_pkg.sv
// ----------------------------------------------------------------------------
// stag_pkg
// Shared types, codes and helper functions of the sign-tagged integer unit.
// ----------------------------------------------------------------------------
package stag_pkg;

    localparam int unsigned WordWidth = 64;

    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_NEG = 4'd5;
    localparam logic [3:0] OP_NOT = 4'd6;
    localparam logic [3:0] OP_AND = 4'd7;
    localparam logic [3:0] OP_OR  = 4'd8;
    localparam logic [3:0] OP_XOR = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [63:0] bits;
        logic        sgn;
        logic [1:0]  st;
    } res_t;

    typedef struct packed {
        logic [3:0]  op;
        logic        na;
        logic        nb;
        logic [63:0] y;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] plo;
        logic        phi_nz;
        res_t        fast;
        logic        lt;
        logic        eq;
    } item_t;

    function automatic res_t ovf_res();
        res_t o;
        o      = '0;
        o.st   = ST_OVF;
        return o;
    endfunction

    function automatic res_t add_uns(logic [63:0] x, logic [63:0] y);
        logic [64:0] s;
        res_t        o;
        s = {1'b0, x} + {1'b0, y};
        o = '0;
        if (s[64])
        begin
            o = ovf_res();
        end
        else
        begin
            o.bits = s[63:0];
        end
        return o;
    endfunction

    function automatic res_t sub_nn(logic [63:0] x, logic [63:0] y);
        logic [64:0] d;
        logic [63:0] r;
        res_t        o;
        d = {1'b0, x} - {1'b0, y};
        r = y - x;
        o = '0;
        if (!d[64] && (d[63:0] != 64'd0))
        begin
            o.bits = d[63:0];
        end
        else if (r > TOP_BIT)
        begin
            o = ovf_res();
        end
        else
        begin
            o.bits = x - y;
            o.sgn  = 1'b1;
        end
        return o;
    endfunction

    function automatic res_t add_op(logic [63:0] a, logic as, logic [63:0] b, logic bs);
        logic        alez;
        logic        blez;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        res_t        o;
        ma   = 64'd0 - a;
        mb   = 64'd0 - b;
        alez = a[63] || (a == 64'd0);
        blez = b[63] || (b == 64'd0);
        r    = ma + mb;
        o    = '0;
        if (as == bs)
        begin
            if (!as)
            begin
                o = add_uns(a, b);
            end
            else if ((alez && !b[63]) || (blez && !a[63]))
            begin
                o.bits = a + b;
                o.sgn  = 1'b1;
            end
            else if (!a[63] && !b[63])
            begin
                o = add_uns(a, b);
            end
            else if ((a == TOP_BIT) || (b == TOP_BIT) || (r > TOP_BIT))
            begin
                o = ovf_res();
            end
            else
            begin
                o.bits = 64'd0 - r;
                o.sgn  = 1'b1;
            end
        end
        else if (as && a[63])
        begin
            o = sub_nn(b, ma);
        end
        else if (bs && b[63])
        begin
            o = sub_nn(a, mb);
        end
        else
        begin
            o = add_uns(a, b);
        end
        return o;
    endfunction

    function automatic res_t sub_op(logic [63:0] a, logic as, logic [63:0] b, logic bs);
        logic        na;
        logic        nb;
        logic [63:0] ma;
        logic [63:0] mb;
        res_t        o;
        na = as && a[63];
        nb = bs && b[63];
        ma = 64'd0 - a;
        mb = 64'd0 - b;
        o  = '0;
        if (!na && !nb)
        begin
            o = sub_nn(a, b);
        end
        else if (nb)
        begin
            if (na)
            begin
                o = sub_nn(mb, ma);
            end
            else
            begin
                o = add_uns(a, mb);
            end
        end
        else if (b > {1'b0, a[62:0]})
        begin
            o = ovf_res();
        end
        else
        begin
            o.bits = a - b;
            o.sgn  = 1'b1;
        end
        return o;
    endfunction

    function automatic res_t neg_op(logic [63:0] a, logic as);
        res_t o;
        o = '0;
        if (as)
        begin
            o.bits = 64'd0 - a;
            o.sgn  = !a[63];
        end
        else if (a > TOP_BIT)
        begin
            o = ovf_res();
        end
        else
        begin
            o.bits = 64'd0 - a;
            o.sgn  = 1'b1;
        end
        return o;
    endfunction

    function automatic logic less_op(logic [63:0] a, logic as, logic [63:0] b, logic bs);
        logic l;
        if (as == bs)
        begin
            if (!as)
            begin
                l = a < b;
            end
            else
            begin
                l = (a ^ TOP_BIT) < (b ^ TOP_BIT);
            end
        end
        else if (as && a[63])
        begin
            l = 1'b1;
        end
        else if (bs && b[63])
        begin
            l = 1'b0;
        end
        else
        begin
            l = a < b;
        end
        return l;
    endfunction

endpackage

FILE: hdl/stag_front.sv
// ----------------------------------------------------------------------------
// stag_front
// First three stages: operand magnitudes, partial products and the results
// of the short operations, then the summed product.
// ----------------------------------------------------------------------------
module stag_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [3:0]         op,
    input  logic [63:0]        a,
    input  logic               as,
    input  logic [63:0]        b,
    input  logic               bs,
    output logic               out_valid,
    output stag_pkg::item_t    out_item
);

    logic              s1_valid_reg;
    logic [3:0]        s1_op_reg;
    logic [63:0]       s1_a_reg;
    logic              s1_as_reg;
    logic [63:0]       s1_b_reg;
    logic              s1_bs_reg;
    logic              s1_na_reg;
    logic              s1_nb_reg;
    logic [63:0]       s1_x_reg;
    logic [63:0]       s1_y_reg;

    logic              s2_valid_reg;
    stag_pkg::item_t   s2_item_reg;
    stag_pkg::item_t   s2_item_next;
    logic [63:0]       pp_ll_reg;
    logic [63:0]       pp_lh_reg;
    logic [63:0]       pp_hl_reg;
    logic [63:0]       pp_hh_reg;

    logic              s3_valid_reg;
    stag_pkg::item_t   s3_item_reg;
    stag_pkg::item_t   s3_item_next;

    logic              na_next;
    logic              nb_next;
    logic [64:0]       mid;
    logic [127:0]      full;

    assign na_next = as && a[63];
    assign nb_next = bs && b[63];

    always_comb
    begin
        s2_item_next        = '0;
        s2_item_next.op     = s1_op_reg;
        s2_item_next.na     = s1_na_reg;
        s2_item_next.nb     = s1_nb_reg;
        s2_item_next.y      = s1_y_reg;
        s2_item_next.quo    = s1_x_reg;
        unique case (s1_op_reg)
            stag_pkg::OP_ADD:
                s2_item_next.fast = stag_pkg::add_op(s1_a_reg, s1_as_reg, s1_b_reg, s1_bs_reg);
            stag_pkg::OP_SUB:
                s2_item_next.fast = stag_pkg::sub_op(s1_a_reg, s1_as_reg, s1_b_reg, s1_bs_reg);
            stag_pkg::OP_NEG:
                s2_item_next.fast = stag_pkg::neg_op(s1_a_reg, s1_as_reg);
            stag_pkg::OP_NOT:
            begin
                s2_item_next.fast.bits = ~s1_a_reg;
                s2_item_next.fast.sgn  = 1'b1;
            end
            stag_pkg::OP_AND:
            begin
                s2_item_next.fast.bits = s1_a_reg & s1_b_reg;
                s2_item_next.fast.sgn  = s1_as_reg && s1_bs_reg;
            end
            stag_pkg::OP_OR:
            begin
                s2_item_next.fast.bits = s1_a_reg | s1_b_reg;
                s2_item_next.fast.sgn  = s1_as_reg || s1_bs_reg;
            end
            stag_pkg::OP_XOR:
            begin
                s2_item_next.fast.bits = s1_a_reg ^ s1_b_reg;
                s2_item_next.fast.sgn  = s1_as_reg != s1_bs_reg;
            end
            stag_pkg::OP_CMP:
            begin
                s2_item_next.lt = stag_pkg::less_op(s1_a_reg, s1_as_reg, s1_b_reg, s1_bs_reg);
                s2_item_next.eq = !s2_item_next.lt
                                  && !stag_pkg::less_op(s1_b_reg, s1_bs_reg, s1_a_reg, s1_as_reg);
            end
            default:
                s2_item_next.fast = '0;
        endcase
    end

    always_comb
    begin
        mid                 = {1'b0, pp_lh_reg} + {1'b0, pp_hl_reg};
        full                = {pp_hh_reg, pp_ll_reg} + {31'd0, mid, 32'd0};
        s3_item_next        = s2_item_reg;
        s3_item_next.plo    = full[63:0];
        s3_item_next.phi_nz = full[127:64] != 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= op;
            s1_a_reg    <= a;
            s1_as_reg   <= as;
            s1_b_reg    <= b;
            s1_bs_reg   <= bs;
            s1_na_reg   <= na_next;
            s1_nb_reg   <= nb_next;
            s1_x_reg    <= na_next ? (64'd0 - a) : a;
            s1_y_reg    <= nb_next ? (64'd0 - b) : b;
            s2_item_reg <= s2_item_next;
            pp_ll_reg   <= s1_x_reg[31:0]  * s1_y_reg[31:0];
            pp_lh_reg   <= s1_x_reg[31:0]  * s1_y_reg[63:32];
            pp_hl_reg   <= s1_x_reg[63:32] * s1_y_reg[31:0];
            pp_hh_reg   <= s1_x_reg[63:32] * s1_y_reg[63:32];
            s3_item_reg <= s3_item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

FILE: hdl/stag_div_step.sv
// ----------------------------------------------------------------------------
// stag_div_step
// One registered step of the restoring divider: one quotient bit a stage.
// ----------------------------------------------------------------------------
module stag_div_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  stag_pkg::item_t    in_item,
    output logic               out_valid,
    output stag_pkg::item_t    out_item
);

    logic              valid_reg;
    stag_pkg::item_t   item_reg;
    stag_pkg::item_t   item_next;
    logic [64:0]       sh;
    logic [64:0]       diff;

    always_comb
    begin
        sh             = {in_item.rem, in_item.quo[63]};
        diff           = sh - {1'b0, in_item.y};
        item_next      = in_item;
        item_next.rem  = diff[64] ? sh[63:0] : diff[63:0];
        item_next.quo  = {in_item.quo[62:0], !diff[64]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: hdl/stag_back.sv
// ----------------------------------------------------------------------------
// stag_back
// Final stage: completes multiply, divide and modulo, picks the result and
// holds it in the output register.
// ----------------------------------------------------------------------------
module stag_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  stag_pkg::item_t    in_item,
    output logic               out_valid,
    output logic [63:0]        result_bits,
    output logic               result_signed,
    output logic [1:0]         status,
    output logic               less,
    output logic               equal
);

    logic              valid_reg;
    stag_pkg::res_t    res_reg;
    stag_pkg::res_t    res_next;
    logic              less_reg;
    logic              equal_reg;
    logic              neg;
    logic [63:0]       q1;
    logic [63:0]       r1;

    always_comb
    begin
        neg      = in_item.na != in_item.nb;
        q1       = in_item.quo + {63'd0, in_item.rem != 64'd0};
        r1       = ((in_item.rem != 64'd0) && neg) ? (in_item.y - in_item.rem) : in_item.rem;
        res_next = '0;
        unique case (in_item.op)
            stag_pkg::OP_MUL:
            begin
                if (in_item.phi_nz)
                begin
                    res_next = stag_pkg::ovf_res();
                end
                else if (!neg)
                begin
                    res_next.bits = in_item.plo;
                end
                else if (in_item.plo > stag_pkg::TOP_BIT)
                begin
                    res_next = stag_pkg::ovf_res();
                end
                else
                begin
                    res_next.bits = 64'd0 - in_item.plo;
                    res_next.sgn  = 1'b1;
                end
            end
            stag_pkg::OP_DIV:
            begin
                if (in_item.y == 64'd0)
                begin
                    res_next.st = stag_pkg::ST_DIV0;
                end
                else if (!neg)
                begin
                    res_next.bits = in_item.quo;
                end
                else if (q1 > stag_pkg::TOP_BIT)
                begin
                    res_next = stag_pkg::ovf_res();
                end
                else
                begin
                    res_next.bits = 64'd0 - q1;
                    res_next.sgn  = 1'b1;
                end
            end
            stag_pkg::OP_MOD:
            begin
                if (in_item.y == 64'd0)
                begin
                    res_next.st = stag_pkg::ST_DIV0;
                end
                else if (r1 == 64'd0)
                begin
                    res_next.sgn = 1'b1;
                end
                else if (in_item.nb)
                begin
                    res_next.bits = 64'd0 - r1;
                    res_next.sgn  = 1'b1;
                end
                else
                begin
                    res_next.bits = r1;
                end
            end
            default:
                res_next = in_item.fast;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg   <= res_next;
            less_reg  <= in_item.lt;
            equal_reg <= in_item.eq;
        end
    end

    assign out_valid     = valid_reg;
    assign result_bits   = res_reg.bits;
    assign result_signed = res_reg.sgn;
    assign status        = res_reg.st;
    assign less          = less_reg;
    assign equal         = equal_reg;

endmodule

FILE: hdl/sign_tagged_checked_integer_alu_core.sv
// ----------------------------------------------------------------------------
// sign_tagged_checked_integer_alu_core
// Pipelined integer unit for 64-bit words with signedness tags, with
// overflow and divide-by-zero status and compare flags.
//
// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   tdata: a_bits, b_bits; tuser: req_type, a_signed, b_signed
// m_axis    out  tdata: result_bits, less, equal; tuser: result_signed, status
//
// One word is taken every cycle unless a result waits in the output register;
// each result passes through three front stages, the 64 one-bit steps of the
// divider and the output register. Reset empties every stage. While a result
// waits in the output register the whole pipeline holds and input is refused.
// ----------------------------------------------------------------------------
module sign_tagged_checked_integer_alu_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,   // a_bits, b_bits
    input  logic [5:0]     s_axis_tuser,   // req_type, a_signed, b_signed
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [71:0]    m_axis_tdata,   // result_bits, less, equal, zero fill
    output logic [2:0]     m_axis_tuser    // result_signed, status
);

    localparam int unsigned Steps = stag_pkg::WordWidth;

    logic              adv;
    logic [Steps:0]    dv;
    stag_pkg::item_t   di [Steps+1];
    logic [63:0]       result_bits;
    logic              result_signed;
    logic [1:0]        status;
    logic              less;
    logic              equal;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    stag_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .op        (s_axis_tuser[3:0]),
        .a         (s_axis_tdata[63:0]),
        .as        (s_axis_tuser[4]),
        .b         (s_axis_tdata[127:64]),
        .bs        (s_axis_tuser[5]),
        .out_valid (dv[0]),
        .out_item  (di[0])
    );

    for (genvar i = 0; i < Steps; i++)
    begin : g_div
        stag_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv[i]),
            .in_item   (di[i]),
            .out_valid (dv[i+1]),
            .out_item  (di[i+1])
        );
    end

    stag_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (dv[Steps]),
        .in_item       (di[Steps]),
        .out_valid     (m_axis_tvalid),
        .result_bits   (result_bits),
        .result_signed (result_signed),
        .status        (status),
        .less          (less),
        .equal         (equal)
    );

    assign m_axis_tdata = {6'd0, equal, less, result_bits};
    assign m_axis_tuser = {status, result_signed};

    a_ready_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input refused while output register is free");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (status != stag_pkg::ST_OK)) |->
        ((result_bits == 64'd0) && !result_signed && !less && !equal))
        else $error("error word carries a result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(less && equal))
        else $error("less and equal both set");

    a_compare_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (less || equal)) |->
        ((result_bits == 64'd0) && !result_signed && (status == stag_pkg::ST_OK)))
        else $error("compare word carries a result");

endmodule

FILE: test/sign_tagged_checked_integer_alu_core_tb.sv
// ----------------------------------------------------------------------------
// sign_tagged_checked_integer_alu_core_tb
// Drives tagged operand words into the integer unit under several idling
// patterns and checks every result word against a local prediction of the
// tagged arithmetic, in order of acceptance.
// ----------------------------------------------------------------------------
module sign_tagged_checked_integer_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] bits;
        logic        sgn;
        logic [1:0]  st;
        logic        lt;
        logic        eq;
    } alu_out_t;

    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors;

        function automatic logic is_neg(logic [63:0] v, logic s);
            return s && v[63];
        endfunction

        function automatic logic [63:0] magnitude(logic [63:0] v, logic s);
            return is_neg(v, s) ? 64'd0 - v : v;
        endfunction

        function automatic logic [65:0] to_exact(logic [63:0] v, logic s);
            return s ? {{2{v[63]}}, v} : {2'b00, v};
        endfunction

        // Fits an exact signed value into a tagged word; positives unsigned when pos_uns is set.
        function automatic void fit(logic signed [65:0] v, logic pos_uns,
                                    output alu_out_t o);
            o = '0;
            if (v > 0 && pos_uns)
            begin
                if (v > 66'sh0_FFFF_FFFF_FFFF_FFFF) o.st = stag_pkg::ST_OVF;
                else o.bits = v[63:0];
            end
            else if (v < -66'sh0_8000_0000_0000_0000 ||
                     v > 66'sh0_7FFF_FFFF_FFFF_FFFF) o.st = stag_pkg::ST_OVF;
            else
            begin
                o.bits = v[63:0];
                o.sgn  = 1'b1;
            end
        endfunction

        function automatic alu_out_t predict(logic [3:0] op, logic [63:0] a, logic as,
                                             logic [63:0] b, logic bs);
            alu_out_t          o;
            logic signed [65:0] ea, eb, sum;
            logic [127:0]      prod;
            logic [63:0]       x, y, q, r;
            logic              na, nb;
            o  = '0;
            ea = to_exact(a, as);
            eb = to_exact(b, bs);
            na = is_neg(a, as);
            nb = is_neg(b, bs);
            x  = magnitude(a, as);
            y  = magnitude(b, bs);
            case (op)
                stag_pkg::OP_ADD:
                begin
                    sum = ea + eb;
                    // Two signed words of opposite sign or with a zero stay signed.
                    fit(sum, !(as && bs && ((na || a == 0) && !nb ||
                                            (nb || b == 0) && !na)), o);
                    // A zero sum of non-negative words not both signed is unsigned.
                    if (sum == 0 && !na && !nb && !(as && bs)) o.sgn = 1'b0;
                end
                stag_pkg::OP_SUB: fit(ea - eb, 1'b1, o);
                stag_pkg::OP_MUL:
                begin
                    prod = x * y;
                    if (prod[127:64] != 0) o.st = stag_pkg::ST_OVF;
                    else if (na == nb) o.bits = prod[63:0];
                    else fit(-$signed({2'b00, prod[63:0]}), 1'b1, o);
                end
                stag_pkg::OP_DIV, stag_pkg::OP_MOD:
                begin
                    if (y == 0) o.st = stag_pkg::ST_DIV0;
                    else
                    begin
                        q = x / y;
                        r = x % y;
                        if (op == stag_pkg::OP_DIV)
                        begin
                            if (na == nb) o.bits = q;
                            else fit(-$signed({2'b00, q + 64'(r != 0)}), 1'b1, o);
                        end
                        else
                        begin
                            if (r != 0 && na != nb) r = y - r;
                            if (r == 0) o.sgn = 1'b1;
                            else if (nb)
                            begin
                                o.bits = 64'd0 - r;
                                o.sgn  = 1'b1;
                            end
                            else o.bits = r;
                        end
                    end
                end
                stag_pkg::OP_NEG:
                begin
                    if (as) fit(-ea, 1'b1, o);
                    else fit(-ea, 1'b0, o);
                    if (as && a == 0) o.sgn = 1'b1;
                end
                stag_pkg::OP_NOT: begin o.bits = ~a; o.sgn = 1'b1; end
                stag_pkg::OP_AND: begin o.bits = a & b; o.sgn = as && bs; end
                stag_pkg::OP_OR:  begin o.bits = a | b; o.sgn = as || bs; end
                stag_pkg::OP_XOR: begin o.bits = a ^ b; o.sgn = as != bs; end
                stag_pkg::OP_CMP:
                begin
                    o.lt = $signed(ea) < $signed(eb);
                    o.eq = ea == eb;
                end
                default: o = '0;
            endcase
            if (o.st != stag_pkg::ST_OK)
            begin
                o.bits = '0;
                o.sgn  = 1'b0;
            end
            return o;
        endfunction

        function void note_word(logic [127:0] data, logic [5:0] user);
            pending.push_back(predict(user[3:0], data[63:0], user[4],
                                      data[127:64], user[5]));
        endfunction

        function void check_word(logic [71:0] data, logic [2:0] user);
            alu_out_t got, want;
            got = {data[63:0], user[0], user[2:1], data[64], data[65]};
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.bits != want.bits || got.sgn != want.sgn || got.st != want.st ||
                got.lt != want.lt || got.eq != want.eq || data[71:66] != 0)
            begin
                $display({"%0t: mismatch, expected %h sgn %b st %0d lt %b eq %b,",
                          " actual %h sgn %b st %0d lt %b eq %b"},
                         $time, want.bits, want.sgn, want.st, want.lt, want.eq,
                         got.bits, got.sgn, got.st, got.lt, got.eq);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [5:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    alu_scoreboard board;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;

    sign_tagged_checked_integer_alu_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #20ms;
        $display("sign_tagged_checked_integer_alu_core verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_word(s_axis_tdata, s_axis_tuser);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: random idling, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n) m_axis_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return stag_pkg::TOP_BIT;
            2: return stag_pkg::TOP_BIT - 64'd1;
            3: return 64'hFFFF_FFFF_FFFF_FFFF;
            4: return stag_pkg::TOP_BIT + 64'd1;
            5: return 64'($urandom_range(16));
            6: return 64'd0 - 64'($urandom_range(16));
            7: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_word(logic [3:0] op, logic [63:0] a, logic as,
                             logic [63:0] b, logic bs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= {bs, as, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [3:0] op;
        repeat (count)
        begin
            op = ($urandom_range(49) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(stag_pkg::OP_CMP));
            send_word(op, pick_operand(), 1'($urandom_range(1)), pick_operand(),
                      1'($urandom_range(1)));
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (board.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    initial
    begin
        logic [3:0] op;
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_cycles   = 0;
        send_idle_pct = 19;
        recv_idle_pct = 83;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(stag_pkg::OP_ADD, stag_pkg::TOP_BIT - 64'd1, 1'b1, 64'd1, 1'b1);
        send_word(stag_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd1, 1'b0);
        send_word(stag_pkg::OP_ADD, stag_pkg::TOP_BIT, 1'b1,
                  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(stag_pkg::OP_ADD, 64'd0, 1'b0, 64'd0, 1'b0);
        send_word(stag_pkg::OP_SUB, 64'd0, 1'b0, stag_pkg::TOP_BIT, 1'b0);
        send_word(stag_pkg::OP_SUB, 64'd0, 1'b0, stag_pkg::TOP_BIT + 64'd1, 1'b0);
        send_word(stag_pkg::OP_SUB, stag_pkg::TOP_BIT, 1'b1, 64'd1, 1'b0);
        send_word(stag_pkg::OP_MUL, stag_pkg::TOP_BIT, 1'b1, 64'd1, 1'b1);
        send_word(stag_pkg::OP_MUL, stag_pkg::TOP_BIT, 1'b0, 64'd2, 1'b0);
        send_word(stag_pkg::OP_DIV, stag_pkg::TOP_BIT, 1'b1,
                  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(stag_pkg::OP_DIV, 64'd7, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        send_word(stag_pkg::OP_DIV, 64'd5, 1'b1, 64'd0, 1'b0);
        send_word(stag_pkg::OP_MOD, 64'd7, 1'b0, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1);
        send_word(stag_pkg::OP_MOD, 64'd6, 1'b1, 64'd3, 1'b1);
        send_word(stag_pkg::OP_MOD, 64'd6, 1'b1, 64'd0, 1'b1);
        send_word(stag_pkg::OP_NEG, stag_pkg::TOP_BIT, 1'b1, 64'd0, 1'b0);
        send_word(stag_pkg::OP_NEG, stag_pkg::TOP_BIT, 1'b0, 64'd0, 1'b0);
        send_word(stag_pkg::OP_NEG, stag_pkg::TOP_BIT + 64'd1, 1'b0, 64'd0, 1'b0);
        send_word(stag_pkg::OP_NEG, 64'd0, 1'b1, 64'd0, 1'b0);
        send_word(stag_pkg::OP_NOT, 64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(stag_pkg::OP_AND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0F0F, 1'b1);
        send_word(stag_pkg::OP_OR,  64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(stag_pkg::OP_XOR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd1, 1'b0);
        send_word(stag_pkg::OP_CMP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                  64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(stag_pkg::OP_CMP, 64'd5, 1'b1, 64'd5, 1'b0);
        op = 4'd15;
        send_word(op, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_random(574);
        drain();

        send_idle_pct = 83;
        recv_idle_pct = 19;
        send_random(400);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        send_random(400);
        drain();
        send_random(400);
        drain();
        repeat (100) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("sign_tagged_checked_integer_alu_core verification clean");
        else
            $display("sign_tagged_checked_integer_alu_core verification failed");
        $finish;
    end
endmodule

FILE: sim.f
hdl/stag_pkg.sv
hdl/stag_front.sv
hdl/stag_div_step.sv
hdl/stag_back.sv
hdl/sign_tagged_checked_integer_alu_core.sv
test/sign_tagged_checked_integer_alu_core_tb.sv
